// ===== hw/rtl/shsam_pkg.sv =====
// Package: shared widths, constants, command/status types and the half-step table.
package shsam_pkg;

  // Field widths
  localparam int unsigned ANGLE_W = 9;
  localparam int unsigned RPM_W   = 4;
  localparam int unsigned COIL_W  = 4;
  localparam int unsigned PHASE_W = 3;
  localparam int unsigned STEP_W  = 3;
  localparam int unsigned SEQ_W   = 10;
  localparam int unsigned HOLD_W  = 14;

  // Sequence count floor(angle * 2^SEQ_SHIFT / SEQ_DIV), taken as
  // (angle * SEQ_RECIP) >> SEQ_RECIP_SHIFT; 128/90 = 64/45 and
  // SEQ_RECIP = ceil(2^21 / 45), exact for every 9-bit angle
  localparam int unsigned SEQ_SHIFT       = 7;
  localparam int unsigned SEQ_DIV         = 90;
  localparam int unsigned SEQ_RECIP_W     = 16;
  localparam logic [SEQ_RECIP_W-1:0] SEQ_RECIP = 16'd46604;
  localparam int unsigned SEQ_RECIP_SHIFT = 15;

  // Hold timing
  localparam int unsigned USEC_PER_MIN      = 60000000;
  localparam int unsigned DEF_STEPS_PER_REV = 4096;
  localparam int unsigned HOLD_MAX          = 16383;
  localparam int unsigned RPM_CODES         = 2 ** RPM_W;

  // Register reset and phase constants
  localparam logic [RPM_W-1:0]   RPM_RESET   = 4'd13;
  localparam logic [PHASE_W-1:0] PHASE_FIRST = 3'd0;
  localparam logic [PHASE_W-1:0] PHASE_LAST  = 3'd7;
  localparam logic [STEP_W-1:0]  STEPS_RELOAD = 3'd7;

  // Item kind codes
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_MOVE = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic exec_item;   // apply a tick or an ignored move, capture result
    logic move_load;   // latch a starting move and its sequence count
    logic start_move;  // commit the new move, capture result
    logic load_out;    // move captured result into the output register
  } shsam_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic start_ok;    // current input beat starts a new move
  } shsam_sts_t;

  // Four-coil half-step drive pattern
  function automatic logic [COIL_W-1:0] half_step_pat(input logic [PHASE_W-1:0] ph);
    logic [COIL_W-1:0] p;
    case (ph)
      3'd0:    p = 4'h1;
      3'd1:    p = 4'h3;
      3'd2:    p = 4'h2;
      3'd3:    p = 4'h6;
      3'd4:    p = 4'h4;
      3'd5:    p = 4'hC;
      3'd6:    p = 4'h8;
      3'd7:    p = 4'h9;
      default: p = 4'h0;
    endcase
    return p;
  endfunction

endpackage

// ===== hw/rtl/shsam_in_if.sv =====
// Interface: input channel carrying tick / move command beats.
interface shsam_in_if;
  import shsam_pkg::*;

  logic               valid;
  logic               ready;
  logic               kind;
  logic [ANGLE_W-1:0] angle_deg;
  logic               direction;

  modport source (output valid, output kind, output angle_deg, output direction,
                  input ready);
  modport sink (input valid, input kind, input angle_deg, input direction,
                output ready);
endinterface

// ===== hw/rtl/shsam_out_if.sv =====
// Interface: result channel carrying coil pattern and status beats.
interface shsam_out_if;
  import shsam_pkg::*;

  logic              valid;
  logic              ready;
  logic [COIL_W-1:0] coils;
  logic              busy_res;
  logic              step_strobe;
  logic              move_done;

  modport source (output valid, output coils, output busy_res, output step_strobe,
                  output move_done, input ready);
  modport sink (input valid, input coils, input busy_res, input step_strobe,
                input move_done, output ready);
endinterface

// ===== hw/rtl/shsam_dp.sv =====
// Datapath: motion state, sequence-count multiplier, hold table and output register.
module shsam_dp #(
  parameter int unsigned STEPS_PER_REV = shsam_pkg::DEF_STEPS_PER_REV
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  shsam_pkg::shsam_cmd_t         cmd,
  output shsam_pkg::shsam_sts_t         sts,
  input  logic                          in_kind,
  input  logic [shsam_pkg::ANGLE_W-1:0] in_angle_deg,
  input  logic                          in_direction,
  input  logic                          cfg_wr_en,
  input  logic [shsam_pkg::RPM_W-1:0]   cfg_wr_data,
  output logic [shsam_pkg::COIL_W-1:0]  out_coils,
  output logic                          out_busy_res,
  output logic                          out_step_strobe,
  output logic                          out_move_done
);
  import shsam_pkg::*;

  localparam int unsigned HOLD_BASE = USEC_PER_MIN / STEPS_PER_REV;

  // Hold period per rpm code, saturated; code zero runs as one rpm
  logic [HOLD_W-1:0] hold_tab [RPM_CODES];
  for (genvar g = 0; g < RPM_CODES; g++) begin : g_hold
    localparam int unsigned HQ  = HOLD_BASE / ((g == 0) ? 1 : g);
    localparam int unsigned HQS = (HQ > HOLD_MAX) ? HOLD_MAX : HQ;
    assign hold_tab[g] = HOLD_W'(HQS);
  end

  logic [RPM_W-1:0]   speed_rpm_r;
  logic [COIL_W-1:0]  coil_r, coil_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [STEP_W-1:0]  steps_r, steps_nxt;
  logic [SEQ_W-1:0]   seq_r, seq_nxt;
  logic [HOLD_W-1:0]  hcnt_r, hcnt_nxt;
  logic [HOLD_W-1:0]  hper_r, hper_nxt;
  logic               dir_r, dir_nxt;
  logic               moving_r, moving_nxt;
  logic               strobe_r, strobe_nxt;
  logic               done_r, done_nxt;

  // Sequence count
  logic [ANGLE_W+SEQ_RECIP_W-1:0] seq_prod;
  logic [SEQ_W-1:0]               quo_r;
  logic [PHASE_W-1:0]             step_phase;
  logic [PHASE_W-1:0]             start_phase;
  logic [HOLD_W-1:0]              new_hper;

  assign sts.start_ok = (in_kind == KIND_MOVE) && !moving_r && (in_angle_deg != '0);

  // Angle times the scaled reciprocal of 90
  assign seq_prod = in_angle_deg * SEQ_RECIP;

  assign step_phase  = dir_r ? (phase_r + 1'b1) : (phase_r - 1'b1);
  assign start_phase = dir_r ? PHASE_FIRST : PHASE_LAST;
  assign new_hper    = hold_tab[speed_rpm_r];

  // Motion state update
  always_comb begin
    coil_nxt   = coil_r;
    phase_nxt  = phase_r;
    steps_nxt  = steps_r;
    seq_nxt    = seq_r;
    hcnt_nxt   = hcnt_r;
    hper_nxt   = hper_r;
    dir_nxt    = dir_r;
    moving_nxt = moving_r;
    strobe_nxt = strobe_r;
    done_nxt   = done_r;
    if (cmd.exec_item) begin
      strobe_nxt = 1'b0;
      done_nxt   = 1'b0;
      if ((in_kind == KIND_TICK) && moving_r) begin
        if (hcnt_r <= HOLD_W'(1)) begin
          if ((steps_r != '0) || (seq_r > SEQ_W'(1))) begin
            if (steps_r != '0) begin
              steps_nxt = steps_r - 1'b1;
            end else begin
              seq_nxt   = seq_r - 1'b1;
              steps_nxt = STEPS_RELOAD;
            end
            phase_nxt  = step_phase;
            coil_nxt   = half_step_pat(step_phase);
            hcnt_nxt   = hper_r;
            strobe_nxt = 1'b1;
          end else begin
            seq_nxt    = '0;
            hcnt_nxt   = '0;
            moving_nxt = 1'b0;
            done_nxt   = 1'b1;
          end
        end else begin
          hcnt_nxt = hcnt_r - 1'b1;
        end
      end
    end else if (cmd.move_load) begin
      dir_nxt = in_direction;
    end else if (cmd.start_move) begin
      moving_nxt = 1'b1;
      seq_nxt    = quo_r;
      steps_nxt  = STEPS_RELOAD;
      hper_nxt   = new_hper;
      hcnt_nxt   = new_hper;
      phase_nxt  = start_phase;
      coil_nxt   = half_step_pat(start_phase);
      strobe_nxt = 1'b1;
      done_nxt   = 1'b0;
    end
  end

  // Control state and config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_rpm_r <= RPM_RESET;
      coil_r      <= '0;
      phase_r     <= '0;
      steps_r     <= '0;
      seq_r       <= '0;
      hcnt_r      <= '0;
      hper_r      <= '0;
      dir_r       <= 1'b0;
      moving_r    <= 1'b0;
      strobe_r    <= 1'b0;
      done_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        speed_rpm_r <= cfg_wr_data;
      end
      coil_r   <= coil_nxt;
      phase_r  <= phase_nxt;
      steps_r  <= steps_nxt;
      seq_r    <= seq_nxt;
      hcnt_r   <= hcnt_nxt;
      hper_r   <= hper_nxt;
      dir_r    <= dir_nxt;
      moving_r <= moving_nxt;
      strobe_r <= strobe_nxt;
      done_r   <= done_nxt;
    end
  end

  // Sequence count latched with the move
  always_ff @(posedge clk) begin
    if (cmd.move_load) begin
      quo_r <= seq_prod[SEQ_RECIP_SHIFT +: SEQ_W];
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_coils       <= coil_r;
      out_busy_res    <= moving_r;
      out_step_strobe <= strobe_r;
      out_move_done   <= done_r;
    end
  end

endmodule

// ===== hw/rtl/shsam_ctrl.sv =====
// Controller: sequences accept, move latch, commit and result hand-off.
module shsam_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  shsam_pkg::shsam_sts_t sts,
  output shsam_pkg::shsam_cmd_t cmd
);
  import shsam_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (sts.start_ok) begin
            cmd.move_load = 1'b1;
            state_nxt     = ST_START;
          end else begin
            cmd.exec_item = 1'b1;
            state_nxt     = ST_EMIT;
          end
        end
      end
      ST_START: begin
        cmd.start_move = 1'b1;
        state_nxt      = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hw/rtl/stepper_half_step_angle_mover_core.sv =====
// Top level: half-step stepper angle mover, controller plus datapath.
//
// Each input beat is a one-microsecond tick (kind 0) or a move command (kind 1,
// angle in whole degrees and direction) and yields exactly one result beat with
// the coil pattern, busy flag, step strobe and move-done flag. A tick or an
// ignored move (zero angle or motor busy) is applied in the accept cycle, then
// ST_EMIT loads the output register, which offers the result. For a move that
// starts, the accept cycle latches the direction and the sequence count
// floor(angle*128/90), taken by one 9x16 multiply with a scaled reciprocal of
// 90, then ST_START commits the move and ST_EMIT loads the output register.
// One beat is in work at a time; the next beat is accepted while the previous
// result still waits in the output register, and a result left unaccepted
// delays the load cycle of the following beat. The hold per half-step comes
// from a constant table indexed by speed_rpm (code 0 runs as 1 rpm, saturated
// at 16383 ticks); speed_rpm is sampled when a move starts and resets to 13.
// The user must write it through cfg_wr_en/cfg_wr_data only while the block
// is idle; the block itself does not enforce this.
module stepper_half_step_angle_mover_core #(
  parameter int unsigned STEPS_PER_REV = shsam_pkg::DEF_STEPS_PER_REV
) (
  input  logic                        clk,
  input  logic                        rst_n,
  shsam_in_if.sink                    in_ch,
  shsam_out_if.source                 out_ch,
  input  logic                        cfg_wr_en,
  input  logic [shsam_pkg::RPM_W-1:0] cfg_wr_data
);
  import shsam_pkg::*;

  shsam_cmd_t cmd;
  shsam_sts_t sts;

  // Sequencer
  shsam_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Motion state and arithmetic
  shsam_dp #(
    .STEPS_PER_REV (STEPS_PER_REV)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_kind         (in_ch.kind),
    .in_angle_deg    (in_ch.angle_deg),
    .in_direction    (in_ch.direction),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_coils       (out_ch.coils),
    .out_busy_res    (out_ch.busy_res),
    .out_step_strobe (out_ch.step_strobe),
    .out_move_done   (out_ch.move_done)
  );

endmodule

// ===== hw/rtl/shsam_chk.sv =====
// Checker: port-level properties of the mover, bound to the top level.
module shsam_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [shsam_pkg::COIL_W-1:0] out_coils,
  input logic                        out_busy_res,
  input logic                        out_step_strobe,
  input logic                        out_move_done
);
  import shsam_pkg::*;

  // A stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // A beat never both steps and finishes
  a_strobe_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_step_strobe && out_move_done))
    else $error("step strobe and move done together");

  // A finished move reports idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_move_done |-> !out_busy_res)
    else $error("move done while still busy");

  // A new step drives a real pattern while busy
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_step_strobe |-> out_busy_res && (out_coils != '0))
    else $error("step strobe without busy or coil drive");

endmodule

bind stepper_half_step_angle_mover_core shsam_chk u_shsam_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_coils       (out_ch.coils),
  .out_busy_res    (out_ch.busy_res),
  .out_step_strobe (out_ch.step_strobe),
  .out_move_done   (out_ch.move_done)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the half-step stepper angle mover core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import shsam_pkg::*;

  localparam int unsigned STEPS_PER_REV = DEF_STEPS_PER_REV;
  localparam int unsigned ANGLE_MAX     = 2 ** ANGLE_W - 1;
  // coil patterns for phases 0..7, phase 0 in the low nibble
  localparam logic [8*COIL_W-1:0] COIL_TABLE =
    {4'h9, 4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1};

  typedef struct packed {
    logic               kind;
    logic [ANGLE_W-1:0] angle_deg;
    logic               direction;
    logic [2:0]         gap;
  } motor_cmd_t;

  typedef struct packed {
    logic [COIL_W-1:0] coils;
    logic              busy_res;
    logic              step_strobe;
    logic              move_done;
  } coil_beat_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [RPM_W-1:0] cfg_wr_data;

  shsam_in_if  in_ch ();
  shsam_out_if out_ch ();

  stepper_half_step_angle_mover_core #(
    .STEPS_PER_REV(STEPS_PER_REV)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  motor_cmd_t cmd_queue[$];
  coil_beat_t coil_expect_q[$];
  int unsigned idle_pct;
  int unsigned fail_cnt;

  // motor state mirror
  logic [RPM_W-1:0]   spd_q;
  logic [COIL_W-1:0]  coil_q;
  logic [PHASE_W-1:0] phase_q;
  logic [3:0]         steps_q;
  logic [SEQ_W-1:0]   seqs_q;
  logic [HOLD_W-1:0]  hold_cnt_q;
  logic [HOLD_W-1:0]  hold_per_q;
  logic               dir_q;
  logic               moving_q;

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [HOLD_W-1:0] hold_for_speed(input logic [RPM_W-1:0] rpm_code);
    int unsigned rpm;
    int unsigned h;
    rpm = (rpm_code == 0) ? 1 : rpm_code;
    h = (USEC_PER_MIN / STEPS_PER_REV) / rpm;
    if (h > HOLD_MAX) h = HOLD_MAX;
    return h[HOLD_W-1:0];
  endfunction

  // advance the motor mirror by one beat, return the result it causes
  function automatic coil_beat_t step_motor(input logic kind, input logic [ANGLE_W-1:0] angle,
                                            input logic dir);
    int unsigned count;
    int unsigned a;
    logic more;
    coil_beat_t r;
    r.step_strobe = 1'b0;
    r.move_done   = 1'b0;
    if (kind == KIND_MOVE) begin
      a = angle;
      count = (a << SEQ_SHIFT) / SEQ_DIV;
      if (!moving_q && count != 0) begin
        moving_q   = 1'b1;
        dir_q      = dir;
        seqs_q     = count[SEQ_W-1:0];
        steps_q    = {1'b0, STEPS_RELOAD};
        hold_per_q = hold_for_speed(spd_q);
        phase_q    = dir ? PHASE_FIRST : PHASE_LAST;
        coil_q     = COIL_TABLE[{phase_q, 2'b00} +: COIL_W];
        hold_cnt_q = hold_per_q;
        r.step_strobe = 1'b1;
      end
    end else if (moving_q) begin
      if (hold_cnt_q <= 1) begin
        more = 1'b1;
        if (steps_q > 0) begin
          steps_q = steps_q - 1'b1;
        end else if (seqs_q > 1) begin
          seqs_q  = seqs_q - 1'b1;
          steps_q = {1'b0, STEPS_RELOAD};
        end else begin
          more = 1'b0;
        end
        if (more) begin
          phase_q    = dir_q ? phase_q + 1'b1 : phase_q - 1'b1;
          coil_q     = COIL_TABLE[{phase_q, 2'b00} +: COIL_W];
          hold_cnt_q = hold_per_q;
          r.step_strobe = 1'b1;
        end else begin
          seqs_q     = '0;
          hold_cnt_q = '0;
          moving_q   = 1'b0;
          r.move_done = 1'b1;
        end
      end else begin
        hold_cnt_q = hold_cnt_q - 1'b1;
      end
    end
    r.coils    = coil_q;
    r.busy_res = moving_q;
    return r;
  endfunction

  function automatic logic [2:0] pick_gap();
    if ($urandom_range(0, 99) < idle_pct) return 3'($urandom_range(0, 7));
    return 3'd0;
  endfunction

  // input driver: gap before each beat, predict on acceptance
  logic [2:0] gap_cnt;
  always @(posedge clk) begin : drive_in
    motor_cmd_t c;
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.kind      <= KIND_TICK;
      in_ch.angle_deg <= '0;
      in_ch.direction <= 1'b0;
      gap_cnt         <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        coil_expect_q.push_back(step_motor(in_ch.kind, in_ch.angle_deg, in_ch.direction));
      if (!in_ch.valid || in_ch.ready) begin
        if (cmd_queue.size() != 0 && gap_cnt >= cmd_queue[0].gap) begin
          c = cmd_queue.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.kind      <= c.kind;
          in_ch.angle_deg <= c.angle_deg;
          in_ch.direction <= c.direction;
          gap_cnt         <= '0;
        end else begin
          in_ch.valid <= 1'b0;
          if (cmd_queue.size() != 0) gap_cnt <= gap_cnt + 1'b1;
        end
      end
    end
  end

  // result monitor: random stall after each beat, compare with oldest expectation
  logic [2:0] stall_left;
  always @(posedge clk) begin : watch_out
    coil_beat_t exp_b;
    logic [2:0] n;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 3'd1;
    end else if (out_ch.valid && out_ch.ready) begin
      if (coil_expect_q.size() == 0) begin
        $display("%0t: result beat with nothing expected, coils %h", $time, out_ch.coils);
        fail_cnt++;
      end else begin
        exp_b = coil_expect_q.pop_front();
        if (out_ch.coils !== exp_b.coils) begin
          $display("%0t: coils expected %h actual %h", $time, exp_b.coils, out_ch.coils);
          fail_cnt++;
        end
        if (out_ch.busy_res !== exp_b.busy_res) begin
          $display("%0t: busy_res expected %b actual %b", $time, exp_b.busy_res,
                   out_ch.busy_res);
          fail_cnt++;
        end
        if (out_ch.step_strobe !== exp_b.step_strobe) begin
          $display("%0t: step_strobe expected %b actual %b", $time, exp_b.step_strobe,
                   out_ch.step_strobe);
          fail_cnt++;
        end
        if (out_ch.move_done !== exp_b.move_done) begin
          $display("%0t: move_done expected %b actual %b", $time, exp_b.move_done,
                   out_ch.move_done);
          fail_cnt++;
        end
      end
      n = pick_gap();
      out_ch.ready <= (n == 0);
      stall_left   <= n;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1'b1;
      out_ch.ready <= (stall_left == 1);
    end
  end

  task automatic push_cmd(input logic kind, input int unsigned angle, input logic dir);
    motor_cmd_t c;
    c.kind      = kind;
    c.angle_deg = angle[ANGLE_W-1:0];
    c.direction = dir;
    c.gap       = pick_gap();
    cmd_queue.push_back(c);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (cmd_queue.size() != 0 || in_ch.valid || coil_expect_q.size() != 0);
  endtask

  task automatic write_speed(input logic [RPM_W-1:0] rpm);
    wait_idle();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= rpm;
    spd_q = rpm;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : stim
    int unsigned n;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= '0;
    rst_n           <= 1'b0;
    fail_cnt = 0;
    idle_pct = 60;
    spd_q      = RPM_RESET;
    coil_q     = '0;
    phase_q    = '0;
    steps_q    = '0;
    seqs_q     = '0;
    hold_cnt_q = '0;
    hold_per_q = '0;
    dir_q      = 1'b0;
    moving_q   = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk);

    // directed: idle ticks and zero-count moves at reset speed
    push_cmd(KIND_TICK, ANGLE_MAX, 1'b1);
    push_cmd(KIND_TICK, 0, 1'b0);
    push_cmd(KIND_MOVE, 0, 1'b0);
    push_cmd(KIND_MOVE, 0, 1'b1);

    // random beats at rest
    idle_pct = 50;
    repeat (8) begin
      if ($urandom_range(0, 2) == 0)
        push_cmd(KIND_MOVE, 0, 1'($urandom_range(0, 1)));
      else
        push_cmd(KIND_TICK, $urandom_range(0, ANGLE_MAX), 1'($urandom_range(0, 1)));
    end

    // fastest code, one move in a random direction
    write_speed(4'd15);
    push_cmd(KIND_MOVE, $urandom_range(1, ANGLE_MAX), 1'($urandom_range(0, 1)));
    // moves while busy are ignored
    push_cmd(KIND_MOVE, 360, 1'b1);
    push_cmd(KIND_MOVE, ANGLE_MAX, 1'b0);
    push_cmd(KIND_MOVE, 1, 1'b1);
    push_cmd(KIND_TICK, 0, 1'b1);
    wait_idle();

    // speed change mid-move must not touch the latched hold
    write_speed(4'd0);
    // tick past the first hold so the next half-step shows
    idle_pct = 8;
    n = hold_per_q + 2;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 1)
        push_cmd(KIND_MOVE, $urandom_range(0, ANGLE_MAX), 1'($urandom_range(0, 1)));
      push_cmd(KIND_TICK, $urandom_range(0, ANGLE_MAX), 1'($urandom_range(0, 1)));
    end
    wait_idle();

    repeat (30) @(posedge clk);
    if (fail_cnt == 0 && coil_expect_q.size() == 0) begin
      $display("stepper_half_step_angle_mover_core: match");
    end else begin
      $display("stepper_half_step_angle_mover_core: mismatch");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #2_000_000;
    $display("stepper_half_step_angle_mover_core: mismatch");
    $finish;
  end

endmodule
